// ----- hw/rtl/ptt_pkg.sv -----
// Shared types and codes for the periodic timer table.
`timescale 1ns / 1ps
package ptt_pkg;
	localparam int SLOTS_DEF  = 16;
	localparam int MAX_EVENTS = 16;
	localparam int EVW        = 5;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_EDIT    = 3'd1,
		OP_ENABLE  = 3'd2,
		OP_DISABLE = 3'd3,
		OP_DELETE  = 3'd4,
		OP_TICK    = 3'd5,
		OP_QEN     = 3'd6,
		OP_QEX     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [31:0]        id;
		logic [31:0]        ivl;
		logic               en;
		logic signed [15:0] lim;
		logic               fnow;
		logic               cb;
		logic               rst;
		logic [31:0]        now;
	} cmd_t;

	// Class of a command, decided at the front
	typedef struct packed {
		logic is_add;
		logic is_tick;
		logic is_lookup;
	} cls_t;

	typedef struct packed {
		cmd_t cmd;
		cls_t cls;
	} item_t;

	typedef struct packed {
		logic [31:0]        id;
		logic [31:0]        ivl;
		logic [31:0]        last;
		logic               en;
		logic signed [15:0] lim;
		logic               fnow;
		logic               cb;
	} entry_t;

	typedef struct packed {
		logic        kind;
		status_t     status;
		logic [31:0] rid;
		logic        answer;
		logic [31:0] code;
		logic        cb;
		logic        last;
	} res_t;
endpackage

// ----- hw/rtl/ptt_front.sv -----
// Front end: input queue of two beats with command classification.
`timescale 1ns / 1ps
module ptt_front
	import ptt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  cmd_t        cmd_in,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_take
);
	item_t       slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	cls_t        cls;
	logic        do_push;
	logic        do_pop;

	// classify on the way in
	always_comb begin
		cls.is_add    = (cmd_in.op == OP_ADD);
		cls.is_tick   = (cmd_in.op == OP_TICK);
		cls.is_lookup = !cls.is_add && !cls.is_tick;
	end

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	// payload storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= '{cmd: cmd_in, cls: cls};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

// ----- hw/rtl/ptt_back.sv -----
// Back end: table memory, scan sequencer and result register.
`timescale 1ns / 1ps
module ptt_back
	import ptt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_take,
	input  logic [31:0] notify_code,
	output logic        out_valid,
	output res_t        out_res,
	input  logic        pop
);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_CHK   = 9'b000000100,
		S_SEND  = 9'b000001000,
		S_ADDWR = 9'b000010000,
		S_SHRD  = 9'b000100000,
		S_SHWR  = 9'b001000000,
		S_REPLY = 9'b010000000,
		S_TEND  = 9'b100000000
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	cls_t        cls_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] cnt_q;
	logic        found_q;
	logic [31:0] max_q;
	logic [EVW-1:0] k_q;
	logic        pend_v_q;
	logic [31:0] pend_id_q;
	logic        pend_cb_q;
	status_t     rep_status_q;
	logic [31:0] rep_id_q;
	logic        rep_ans_q;
	logic        out_v_q;
	res_t        out_q;

	entry_t      mem_q [SLOTS];
	entry_t      rdata_q;
	logic        we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	entry_t      wdata;

	logic        out_free;
	logic        out_load;
	logic        match;
	logic        fire;
	logic        go;
	logic [CW:0] ptr_inc;
	logic        mod_op;
	entry_t      e_fire;
	entry_t      e_mod;
	logic signed [15:0] lim_dec;

	assign out_free  = !out_v_q || pop;
	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign item_take = (state_q == S_IDLE);
	assign match     = (rdata_q.id == cmd_q.id);
	assign ptr_inc   = (CW + 1)'(ptr_q) + 1'b1;
	assign mod_op    = (cmd_q.op == OP_EDIT) || (cmd_q.op == OP_ENABLE)
		|| (cmd_q.op == OP_DISABLE);

	// tick decision and updated entry
	always_comb begin
		fire = rdata_q.en && (rdata_q.fnow || ((cmd_q.now - rdata_q.last) > rdata_q.ivl));
		go   = !fire || !pend_v_q || out_free;
		lim_dec = (rdata_q.lim > 16'sd0) ? rdata_q.lim - 16'sd1 : rdata_q.lim;
		e_fire = rdata_q;
		e_fire.fnow = 1'b0;
		e_fire.last = cmd_q.now;
		if (!rdata_q.cb) begin
			e_fire.lim = lim_dec;
			if (lim_dec == 16'sd0) e_fire.en = 1'b0;
		end
	end

	// edit, enable and disable on a found entry
	always_comb begin
		e_mod = rdata_q;
		if (cmd_q.op == OP_EDIT) begin
			if (cmd_q.ivl != 32'd0) e_mod.ivl = cmd_q.ivl;
			if (cmd_q.cb) e_mod.cb = 1'b1;
			e_mod.en   = cmd_q.en;
			e_mod.lim  = cmd_q.lim;
			if (cmd_q.en) e_mod.last = cmd_q.now;
			e_mod.fnow = cmd_q.fnow;
		end else begin
			if (cmd_q.rst) e_mod.last = cmd_q.now;
			e_mod.en = (cmd_q.op == OP_ENABLE);
		end
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q[AW-1:0];
		wdata = rdata_q;
		raddr = ptr_q[AW-1:0];
		case (state_q)
			S_CHK: begin
				if (cls_q.is_tick && fire && go) begin
					we    = 1'b1;
					wdata = e_fire;
				end else if (cls_q.is_lookup && match && mod_op) begin
					we    = 1'b1;
					wdata = e_mod;
				end
			end
			S_ADDWR: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata.id   = found_q ? max_q + 32'd1 : cmd_q.id;
				wdata.ivl  = cmd_q.ivl;
				wdata.last = cmd_q.now;
				wdata.en   = cmd_q.en;
				wdata.lim  = cmd_q.lim;
				wdata.fnow = cmd_q.fnow;
				wdata.cb   = cmd_q.cb;
			end
			S_SHRD: raddr = ptr_inc[AW-1:0];
			S_SHWR: we = 1'b1;
			default: ;
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	// result register load
	always_comb begin
		case (state_q)
			S_CHK:   out_load = cls_q.is_tick && fire && go && pend_v_q;
			S_REPLY: out_load = out_free;
			S_TEND:  out_load = pend_v_q && out_free;
			default: out_load = 1'b0;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ptr_q    <= '0;
			k_q      <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cmd_q     <= item.cmd;
						cls_q     <= item.cls;
						ptr_q     <= '0;
						k_q       <= '0;
						found_q   <= 1'b0;
						max_q     <= '0;
						pend_v_q  <= 1'b0;
						rep_id_q  <= '0;
						rep_ans_q <= 1'b0;
						rep_status_q <= ST_OK;
						if (item.cls.is_add && cnt_q >= CW'(SLOTS)) begin
							rep_status_q <= ST_FULL;
							state_q <= S_REPLY;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= (ptr_q >= cnt_q) ? S_SEND : S_CHK;
				end
				S_CHK: begin
					if (cls_q.is_add) begin
						if (match) found_q <= 1'b1;
						if (rdata_q.id > max_q) max_q <= rdata_q.id;
						ptr_q   <= ptr_inc[CW-1:0];
						state_q <= S_RD;
					end else if (cls_q.is_tick) begin
						if (!fire) begin
							ptr_q   <= ptr_inc[CW-1:0];
							state_q <= S_RD;
						end else if (go) begin
							// hand the previous event out, hold this one
							if (pend_v_q) begin
								out_q   <= '{kind: 1'b1, status: ST_OK, rid: pend_id_q,
									answer: 1'b0, code: notify_code, cb: pend_cb_q,
									last: 1'b0};
							end
							pend_v_q  <= 1'b1;
							pend_id_q <= rdata_q.id;
							pend_cb_q <= rdata_q.cb;
							k_q       <= k_q + 1'b1;
							ptr_q     <= ptr_inc[CW-1:0];
							state_q   <= (k_q == EVW'(MAX_EVENTS - 1)) ? S_TEND : S_RD;
						end
					end else if (match) begin
						case (cmd_q.op)
							OP_QEN: begin
								rep_ans_q <= rdata_q.en;
								state_q   <= S_REPLY;
							end
							OP_QEX: begin
								rep_ans_q <= 1'b1;
								state_q   <= S_REPLY;
							end
							OP_DELETE: state_q <= S_SHRD;
							default:   state_q <= S_REPLY;
						endcase
					end else begin
						ptr_q   <= ptr_inc[CW-1:0];
						state_q <= S_RD;
					end
				end
				S_SEND: begin
					if (cls_q.is_add) begin
						state_q <= S_ADDWR;
					end else if (cls_q.is_tick) begin
						state_q <= S_TEND;
					end else begin
						if (cmd_q.op != OP_QEX) rep_status_q <= ST_NOTFOUND;
						state_q <= S_REPLY;
					end
				end
				S_ADDWR: begin
					rep_id_q <= found_q ? max_q + 32'd1 : cmd_q.id;
					cnt_q    <= cnt_q + 1'b1;
					state_q  <= S_REPLY;
				end
				S_SHRD: begin
					if (ptr_inc >= (CW + 1)'(cnt_q)) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_REPLY;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					ptr_q   <= ptr_inc[CW-1:0];
					state_q <= S_SHRD;
				end
				S_REPLY: begin
					if (out_free) begin
						out_q   <= '{kind: 1'b0, status: rep_status_q, rid: rep_id_q,
							answer: rep_ans_q, code: 32'd0, cb: 1'b0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_TEND: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q    <= '{kind: 1'b1, status: ST_OK, rid: pend_id_q,
							answer: 1'b0, code: notify_code, cb: pend_cb_q, last: 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/periodic_timer_table_top.sv -----
// Periodic timer table: top level with config register and port mapping.
// Commands walk the table from the first entry: a lookup stops at its id, an absent
// id or an add walks all entries (a full add replies at once), a delete then moves each
// later entry down a slot, and a tick walks the entries and may stall on results. One
// item is worked at a time; a two-beat input queue keeps taking beats meanwhile.
// Reset clears the entry count, queues and notify code; table contents are not cleared.
`timescale 1ns / 1ps
module periodic_timer_table_top
	import ptt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         opcode,
	input  logic [31:0]        timer_id,
	input  logic [31:0]        interval,
	input  logic               enable_flag,
	input  logic signed [15:0] fire_limit,
	input  logic               fire_now,
	input  logic               uses_callback,
	input  logic               reset_time,
	input  logic [31:0]        now_time,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output logic               empty,
	input  logic               pop,
	output logic               kind,
	output logic [1:0]         status,
	output logic [31:0]        result_id,
	output logic               answer,
	output logic [31:0]        event_code,
	output logic               by_callback,
	output logic               last_result
);
	cmd_t        cmd_in;
	item_t       item;
	logic        item_valid;
	logic        item_take;
	logic        out_valid;
	res_t        out_res;
	logic [31:0] notify_q;

	assign cmd_in = '{op: op_t'(opcode), id: timer_id, ivl: interval, en: enable_flag,
		lim: fire_limit, fnow: fire_now, cb: uses_callback, rst: reset_time,
		now: now_time};

	// notify code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) notify_q <= '0;
		else if (cfg_we) notify_q <= cfg_wdata;
	end

	ptt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd_in     (cmd_in),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	ptt_back #(.SLOTS(SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take),
		.notify_code (notify_q),
		.out_valid   (out_valid),
		.out_res     (out_res),
		.pop         (pop)
	);

	assign empty       = !out_valid;
	assign kind        = out_res.kind;
	assign status      = out_res.status;
	assign result_id   = out_res.rid;
	assign answer      = out_res.answer;
	assign event_code  = out_res.code;
	assign by_callback = out_res.cb;
	assign last_result = out_res.last;
endmodule

// ----- hw/rtl/ptt_checker.sv -----
// Port-level checks for the periodic timer table, bound to the top level.
`timescale 1ns / 1ps
module ptt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [1:0]  status,
	input logic        answer,
	input logic        last_result
);
	// a waiting result stays until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result dropped without pop");

	// events carry no status and no answer
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind |-> status == 2'd0 && !answer) else $error("bad event fields");

	// every reply closes its operation
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !kind |-> last_result) else $error("reply not last");

	// no unused status code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != 2'd3) else $error("illegal status");
endmodule

bind periodic_timer_table_top ptt_checker u_chk (.*);

// ----- bench/periodic_timer_table_top_tb.sv -----
// Self-checking testbench for the periodic timer table top level.
`timescale 1ns / 1ps
module periodic_timer_table_top_tb;
	import ptt_pkg::*;

	localparam int NSLOT = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic        kind;
		status_t     status;
		logic [31:0] rid;
		logic        answer;
		logic [31:0] code;
		logic        cb;
		logic        last;
	} beat_t;

	typedef struct {
		op_t                op;
		logic [31:0]        id;
		logic [31:0]        ivl;
		logic               en;
		logic signed [15:0] lim;
		logic               fnow;
		logic               cb;
		logic               rst;
		logic [31:0]        now;
		logic               typed;
		status_t            x_status;
		logic [31:0]        x_rid;
		logic               x_answer;
	} row_t;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [2:0] opcode;
	logic [31:0] timer_id, interval, now_time, cfg_wdata;
	logic enable_flag, fire_now, uses_callback, reset_time, cfg_we;
	logic signed [15:0] fire_limit;
	logic kind, answer, by_callback, last_result;
	logic [1:0] status;
	logic [31:0] result_id, event_code;

	// timer table image
	int unsigned tbl_count;
	logic [31:0] tbl_id [NSLOT];
	logic [31:0] tbl_ivl [NSLOT];
	logic [31:0] tbl_last [NSLOT];
	logic tbl_en [NSLOT];
	logic signed [15:0] tbl_lim [NSLOT];
	logic tbl_fnow [NSLOT];
	logic tbl_cb [NSLOT];
	logic [31:0] notify_val;

	beat_t pending_beats[$];
	int errors;
	int idle_cycles;
	bit calm;       // no idling in the last part
	bit hold_off;   // long receiver stall
	logic [31:0] clock_now;

	periodic_timer_table_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .timer_id(timer_id), .interval(interval),
		.enable_flag(enable_flag), .fire_limit(fire_limit), .fire_now(fire_now),
		.uses_callback(uses_callback), .reset_time(reset_time), .now_time(now_time),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .empty(empty), .pop(pop),
		.kind(kind), .status(status), .result_id(result_id), .answer(answer),
		.event_code(event_code), .by_callback(by_callback), .last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int find_timer(logic [31:0] id);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic beat_t reply(status_t st, logic [31:0] rid, logic ans);
		beat_t b;
		b = '{1'b0, st, rid, ans, 32'd0, 1'b0, 1'b1};
		return b;
	endfunction

	// append one expected beat
	function automatic void queue_beat(beat_t b);
		pending_beats = {pending_beats, b};
	endfunction

	// Apply one command to the table image and queue the beats it causes
	task automatic predict_timer_op(row_t r);
		int s;
		int k;
		logic [31:0] id, mx;
		beat_t b;
		s = -1;
		k = 0;
		id = r.id;
		if (r.op != OP_ADD && r.op != OP_TICK) s = find_timer(r.id);
		case (r.op)
			OP_ADD: begin
				if (tbl_count >= NSLOT) begin
					queue_beat(reply(ST_FULL, 32'd0, 1'b0));
				end else begin
					if (find_timer(id) >= 0) begin
						mx = 0;
						for (int i = 0; i < tbl_count; i++)
							if (tbl_id[i] > mx) mx = tbl_id[i];
						id = mx + 32'd1;
					end
					tbl_id[tbl_count] = id;
					tbl_ivl[tbl_count] = r.ivl;
					tbl_cb[tbl_count] = r.cb;
					tbl_en[tbl_count] = r.en;
					tbl_lim[tbl_count] = r.lim;
					tbl_last[tbl_count] = r.now;
					tbl_fnow[tbl_count] = r.fnow;
					tbl_count++;
					queue_beat(reply(ST_OK, id, 1'b0));
				end
			end
			OP_EDIT: begin
				if (s >= 0) begin
					if (r.ivl != 0) tbl_ivl[s] = r.ivl;
					if (r.cb) tbl_cb[s] = 1'b1;
					tbl_en[s] = r.en;
					tbl_lim[s] = r.lim;
					if (r.en) tbl_last[s] = r.now;
					tbl_fnow[s] = r.fnow;
				end
				queue_beat(reply(s < 0 ? ST_NOTFOUND : ST_OK, 32'd0, 1'b0));
			end
			OP_ENABLE, OP_DISABLE: begin
				if (s >= 0) begin
					if (r.rst) tbl_last[s] = r.now;
					tbl_en[s] = (r.op == OP_ENABLE);
				end
				queue_beat(reply(s < 0 ? ST_NOTFOUND : ST_OK, 32'd0, 1'b0));
			end
			OP_DELETE: begin
				if (s >= 0) begin
					for (int i = s; i + 1 < tbl_count; i++) begin
						tbl_id[i] = tbl_id[i + 1];
						tbl_ivl[i] = tbl_ivl[i + 1];
						tbl_last[i] = tbl_last[i + 1];
						tbl_en[i] = tbl_en[i + 1];
						tbl_lim[i] = tbl_lim[i + 1];
						tbl_fnow[i] = tbl_fnow[i + 1];
						tbl_cb[i] = tbl_cb[i + 1];
					end
					tbl_count--;
				end
				queue_beat(reply(s < 0 ? ST_NOTFOUND : ST_OK, 32'd0, 1'b0));
			end
			OP_TICK: begin
				for (int i = 0; i < tbl_count && k < MAX_EVENTS; i++) begin
					if (!tbl_en[i]) continue;
					if (!tbl_fnow[i] && (r.now - tbl_last[i]) <= tbl_ivl[i]) continue;
					b = '{1'b1, ST_OK, tbl_id[i], 1'b0, notify_val, tbl_cb[i], 1'b0};
					queue_beat(b);
					k++;
					if (!tbl_cb[i]) begin
						if (tbl_lim[i] > 0) tbl_lim[i]--;
						if (tbl_lim[i] == 0) tbl_en[i] = 1'b0;
					end
					tbl_fnow[i] = 1'b0;
					tbl_last[i] = r.now;
				end
				if (k > 0) pending_beats[$].last = 1'b1;
			end
			OP_QEN: queue_beat(reply(s < 0 ? ST_NOTFOUND : ST_OK, 32'd0,
				s < 0 ? 1'b0 : tbl_en[s]));
			default: queue_beat(reply(ST_OK, 32'd0, s >= 0));
		endcase
	endtask

	// Send one command, waiting for the queue to take it
	task automatic send_cmd(row_t r, bit gaps);
		int depth_before;
		if (gaps && !calm && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= r.op;
		timer_id <= r.id;
		interval <= r.ivl;
		enable_flag <= r.en;
		fire_limit <= r.lim;
		fire_now <= r.fnow;
		uses_callback <= r.cb;
		reset_time <= r.rst;
		now_time <= r.now;
		do @(posedge clk); while (full);
		depth_before = pending_beats.size();
		predict_timer_op(r);
		// typed expectation for plain directed rows
		if (r.typed && pending_beats.size() == depth_before + 1) begin
			if (pending_beats[$].status !== r.x_status) begin
				$error("table row status exp %0d got %0d", r.x_status,
					pending_beats[$].status);
				errors++;
			end
			if (pending_beats[$].rid !== r.x_rid) begin
				$error("table row result_id exp %0h got %0h", r.x_rid,
					pending_beats[$].rid);
				errors++;
			end
			if (pending_beats[$].answer !== r.x_answer) begin
				$error("table row answer exp %0d got %0d", r.x_answer,
					pending_beats[$].answer);
				errors++;
			end
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (2 * NSLOT * 3 + 20) @(posedge clk);
	endtask

	task automatic write_notify(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		notify_val = v;
	endtask

	function automatic row_t mk(op_t op, logic [31:0] id, logic [31:0] ivl, logic en,
			logic signed [15:0] lim, logic fnow, logic cb, logic rst, logic [31:0] now);
		row_t r;
		r = '{op, id, ivl, en, lim, fnow, cb, rst, now, 1'b0, ST_OK, 32'd0, 1'b0};
		return r;
	endfunction

	function automatic row_t chk(row_t r, status_t st, logic [31:0] rid, logic ans);
		r.typed = 1'b1;
		r.x_status = st;
		r.x_rid = rid;
		r.x_answer = ans;
		return r;
	endfunction

	// Random command, mostly aimed at ids present in the table
	function automatic row_t rand_cmd();
		row_t r;
		int pick;
		logic [31:0] id;
		clock_now += $urandom_range(0, 40);
		if (tbl_count > 0 && $urandom_range(0, 9) < 7)
			id = tbl_id[$urandom_range(0, tbl_count - 1)];
		else if ($urandom_range(0, 1))
			id = $urandom;
		else
			id = $urandom_range(0, 20);
		pick = $urandom_range(0, 15);
		r = mk(OP_TICK, id, $urandom_range(0, 60), 1'($urandom_range(0, 1)),
			$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)) - 16'sd1,
			$urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
			$urandom_range(0, 9) == 0 ? $urandom : clock_now);
		if ($urandom_range(0, 7) == 0) r.ivl = $urandom;
		case (pick)
			0, 1, 2: r.op = (tbl_count < 12 || pick == 0) ? OP_ADD : OP_DELETE;
			3: r.op = OP_EDIT;
			4: r.op = OP_ENABLE;
			5: r.op = OP_DISABLE;
			6: r.op = OP_DELETE;
			7: r.op = OP_QEN;
			8: r.op = OP_QEX;
			default: r.op = OP_TICK;
		endcase
		return r;
	endfunction

	// Receiver: random pop gaps, one long stall, checks every beat
	initial begin
		beat_t x;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (pending_beats.size() == 0) begin
					$error("unexpected beat: kind %0d rid %0h", kind, result_id);
					errors++;
				end else begin
					x = pending_beats.pop_front();
					if (kind !== x.kind) begin
						$error("kind exp %0d got %0d", x.kind, kind); errors++;
					end
					if (status !== x.status) begin
						$error("status exp %0d got %0d", x.status, status); errors++;
					end
					if (result_id !== x.rid) begin
						$error("result_id exp %0h got %0h", x.rid, result_id); errors++;
					end
					if (answer !== x.answer) begin
						$error("answer exp %0d got %0d", x.answer, answer); errors++;
					end
					if (event_code !== x.code) begin
						$error("event_code exp %0h got %0h", x.code, event_code); errors++;
					end
					if (by_callback !== x.cb) begin
						$error("by_callback exp %0d got %0d", x.cb, by_callback); errors++;
					end
					if (last_result !== x.last) begin
						$error("last_result exp %0d got %0d", x.last, last_result); errors++;
					end
				end
			end
			if (hold_off) begin
				pop <= 1'b0;
				repeat (150) @(posedge clk);
				hold_off = 1'b0;
				pop <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no beat moving
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("periodic_timer_table_top_tb NOT OK");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		row_t rows[$];
		row_t r;
		errors = 0;
		calm = 1'b0;
		hold_off = 1'b0;
		clock_now = 32'd1000;
		tbl_count = 0;
		notify_val = 32'd0;
		arst_n = 1'b0;
		push = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 32'd0;
		opcode = OP_ADD;
		timer_id = 32'd0;
		interval = 32'd0;
		enable_flag = 1'b0;
		fire_limit = 16'sd0;
		fire_now = 1'b0;
		uses_callback = 1'b0;
		reset_time = 1'b0;
		now_time = 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, clash, counting, compaction
		rows = {rows, chk(mk(OP_QEX, 32'd5, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_OK, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_QEN, 32'd5, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_NOTFOUND, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_EDIT, 32'd5, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_NOTFOUND, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_ENABLE, 32'd5, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b1, 32'd0),
			ST_NOTFOUND, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_DISABLE, 32'd5, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b1, 32'd0),
			ST_NOTFOUND, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_DELETE, 32'd5, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_NOTFOUND, 32'd0, 1'b0)};
		rows = {rows, mk(OP_TICK, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd100)};
		rows = {rows, chk(mk(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'sh7FFF, 1'b1,
			1'b1, 1'b1, 32'hFFFF_FFFF), ST_OK, 32'hFFFF_FFFF, 1'b0)};
		// clash with the largest id wraps to zero
		rows = {rows, chk(mk(OP_ADD, 32'hFFFF_FFFF, 32'd0, 1'b1, -16'sd32768, 1'b0, 1'b0,
			1'b0, 32'd0), ST_OK, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_ADD, 32'd7, 32'd3, 1'b1, 16'sd2, 1'b0, 1'b0, 1'b0, 32'd10),
			ST_OK, 32'd7, 1'b0)};
		rows = {rows, mk(OP_TICK, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd20)};
		rows = {rows, mk(OP_TICK, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd30)};
		rows = {rows, chk(mk(OP_QEN, 32'd7, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_OK, 32'd0, 1'b0)};
		rows = {rows, mk(OP_EDIT, 32'd7, 32'd0, 1'b1, -16'sd1, 1'b1, 1'b1, 1'b0, 32'd40)};
		rows = {rows, mk(OP_ENABLE, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b1, 32'd50)};
		rows = {rows, mk(OP_DISABLE, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0,
			32'd60)};
		rows = {rows, mk(OP_TICK, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd70)};
		rows = {rows, chk(mk(OP_DELETE, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0,
			32'd0), ST_OK, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_QEX, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0,
			32'd0), ST_OK, 32'd0, 1'b0)};
		rows = {rows, chk(mk(OP_QEX, 32'd7, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_OK, 32'd0, 1'b1)};
		foreach (rows[i]) send_cmd(rows[i], 1'b1);
		wait_drained();

		// fill the table with fire-now entries; full add, then a sixteen-event tick
		write_notify(32'hFFFF_FFFF);
		for (int i = 0; i < 16; i++)
			send_cmd(mk(OP_ADD, 32'd100 + i, 32'd5, 1'b1, -16'sd1, 1'b1, 1'(i % 2), 1'b0,
				32'd80), 1'b1);
		send_cmd(chk(mk(OP_ADD, 32'd1, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
			ST_FULL, 32'd0, 1'b0), 1'b1);
		hold_off = 1'b1;
		send_cmd(mk(OP_TICK, 32'd0, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd81), 1'b0);
		for (int i = 0; i < 6; i++)
			send_cmd(mk(OP_QEX, 32'd100 + i, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0, 32'd0),
				1'b0);
		for (int i = 0; i < 16; i++)
			send_cmd(mk(OP_DELETE, 32'd100 + i, 32'd0, 1'b0, 16'sd0, 1'b0, 1'b0, 1'b0,
				32'd0), 1'b1);
		wait_drained();

		// random phases under several notify codes
		for (int ph = 0; ph < 4; ph++) begin
			write_notify(ph == 0 ? 32'd0 : ph == 1 ? 32'h8000_0001 : $urandom);
			if (ph == 3) calm = 1'b1;
			for (int n = 0; n < 38; n++) begin
				r = rand_cmd();
				send_cmd(r, 1'b1);
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("periodic_timer_table_top_tb OK");
		end else begin
			$display("periodic_timer_table_top_tb NOT OK");
		end
		$finish;
	end
endmodule
